>>> src/ncs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NAND command sequencer package
// Shared types and codes, and the per-step bus cycle lookup used by the back
// sequencer.
// ----------------------------------------------------------------------------
package ncs_pkg;

   // Request operation codes
   localparam logic [3:0] OP_READ_SETUP  = 4'd0;
   localparam logic [3:0] OP_PROG_SETUP  = 4'd1;
   localparam logic [3:0] OP_PROG_COMMIT = 4'd2;
   localparam logic [3:0] OP_BYTE_READ   = 4'd3;
   localparam logic [3:0] OP_BYTE_PROG   = 4'd4;
   localparam logic [3:0] OP_ERASE       = 4'd5;
   localparam logic [3:0] OP_VERDICT     = 4'd6;
   localparam logic [3:0] OP_SELECT      = 4'd7;
   localparam logic [3:0] OP_DESELECT    = 4'd8;
   localparam logic [3:0] OP_WRITE_DATA  = 4'd9;
   localparam logic [3:0] OP_READ_DATA   = 4'd10;

   // Flash command bytes
   localparam logic [7:0] CMD_READ0     = 8'h00;
   localparam logic [7:0] CMD_READ1     = 8'h01;
   localparam logic [7:0] CMD_READ_OOB  = 8'h50;
   localparam logic [7:0] CMD_PROG      = 8'h80;
   localparam logic [7:0] CMD_PROG_GO   = 8'h10;
   localparam logic [7:0] CMD_STATUS    = 8'h70;
   localparam logic [7:0] CMD_ERASE     = 8'h60;
   localparam logic [7:0] CMD_ERASE_GO  = 8'hD0;

   // Address geometry
   localparam int PAGE_BITS        = 9;   // 512-byte page
   localparam int HALF_PAGE_BIT    = 8;   // second half of page selects READ1
   localparam int ERASE_ALIGN_BITS = 14;  // 16 KiB erase block
   localparam int QUEUE_DEPTH      = 2;

   // Longest recipe is byte program: 13 steps
   localparam int MAX_STEPS = 13;
   localparam int STEP_W    = $clog2(MAX_STEPS);

   typedef enum logic [3:0] {
      KIND_SEL     = 4'd0,
      KIND_DESEL   = 4'd1,
      KIND_CLRRB   = 4'd2,
      KIND_CMD     = 4'd3,
      KIND_ADDR    = 4'd4,
      KIND_WRITE   = 4'd5,
      KIND_READ    = 4'd6,
      KIND_WAIT    = 4'd7,
      KIND_ALIGN   = 4'd8,
      KIND_VERDICT = 4'd9
   } kind_type;

   typedef enum logic [3:0] {
      REC_ALIGN,
      REC_READ_SETUP,
      REC_PROG_SETUP,
      REC_COMMIT,
      REC_BYTE_READ,
      REC_BYTE_PROG,
      REC_ERASE,
      REC_VERDICT,
      REC_SELECT,
      REC_DESELECT,
      REC_WRITE,
      REC_READ
   } recipe_type;

   // Classified request as it waits in the queue
   typedef struct packed {
      recipe_type recipe;
      logic [7:0] cmd;     // first command byte where it varies
      logic [7:0] data;    // write byte, or verdict bit
      logic [7:0] addr0;   // addr[7:0]
      logic [7:0] addr1;   // addr[16:9]
      logic [7:0] addr2;   // addr[24:17]
      logic [7:0] addr3;   // addr[31:25]
   } job_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } cycle_type;

   function automatic cycle_type mk(kind_type k, logic [7:0] v, logic l);
      cycle_type c;
      c.kind  = k;
      c.value = v;
      c.last  = l;
      return c;
   endfunction

   function automatic logic [7:0] addr_byte(job_type j, logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = j.addr0;
         2'd1: b = j.addr1;
         2'd2: b = j.addr2;
         2'd3: b = j.addr3;
         default: b = j.addr0;
      endcase
      return b;
   endfunction

   // Bus cycle for a given recipe step
   function automatic cycle_type seq_cycle(job_type j, logic [STEP_W-1:0] s);
      cycle_type c;
      c = mk(KIND_ALIGN, 8'h00, 1'b1);
      unique case (j.recipe)
         REC_ALIGN:    c = mk(KIND_ALIGN, 8'h00, 1'b1);
         REC_VERDICT:  c = mk(KIND_VERDICT, j.data, 1'b1);
         REC_SELECT:   c = mk(KIND_SEL, 8'h00, 1'b1);
         REC_DESELECT: c = mk(KIND_DESEL, 8'h00, 1'b1);
         REC_WRITE:    c = mk(KIND_WRITE, j.data, 1'b1);
         REC_READ:     c = mk(KIND_READ, 8'h00, 1'b1);
         REC_READ_SETUP: begin
            unique case (s)
               4'd0: c = mk(KIND_CLRRB, 8'h00, 1'b0);
               4'd1: c = mk(KIND_CMD, j.cmd, 1'b0);
               4'd2, 4'd3, 4'd4, 4'd5:
                  c = mk(KIND_ADDR, addr_byte(j, 2'(s - 4'd2)), 1'b0);
               default: c = mk(KIND_WAIT, 8'h00, 1'b1);
            endcase
         end
         REC_PROG_SETUP: begin
            unique case (s)
               4'd0: c = mk(KIND_CLRRB, 8'h00, 1'b0);
               4'd1: c = mk(KIND_CMD, j.cmd, 1'b0);
               4'd2, 4'd3, 4'd4:
                  c = mk(KIND_ADDR, addr_byte(j, 2'(s - 4'd2)), 1'b0);
               default: c = mk(KIND_ADDR, j.addr3, 1'b1);
            endcase
         end
         REC_COMMIT: begin
            unique case (s)
               4'd0: c = mk(KIND_CMD, CMD_PROG_GO, 1'b0);
               4'd1: c = mk(KIND_WAIT, 8'h00, 1'b0);
               4'd2: c = mk(KIND_CMD, CMD_STATUS, 1'b0);
               default: c = mk(KIND_READ, 8'h00, 1'b1);
            endcase
         end
         REC_BYTE_READ: begin
            unique case (s)
               4'd0: c = mk(KIND_SEL, 8'h00, 1'b0);
               4'd1: c = mk(KIND_CLRRB, 8'h00, 1'b0);
               4'd2: c = mk(KIND_CMD, j.cmd, 1'b0);
               4'd3, 4'd4, 4'd5, 4'd6:
                  c = mk(KIND_ADDR, addr_byte(j, 2'(s - 4'd3)), 1'b0);
               4'd7: c = mk(KIND_WAIT, 8'h00, 1'b0);
               4'd8: c = mk(KIND_READ, 8'h00, 1'b0);
               default: c = mk(KIND_DESEL, 8'h00, 1'b1);
            endcase
         end
         REC_BYTE_PROG: begin
            unique case (s)
               4'd0: c = mk(KIND_SEL, 8'h00, 1'b0);
               4'd1: c = mk(KIND_CLRRB, 8'h00, 1'b0);
               4'd2: c = mk(KIND_CMD, CMD_PROG, 1'b0);
               4'd3, 4'd4, 4'd5, 4'd6:
                  c = mk(KIND_ADDR, addr_byte(j, 2'(s - 4'd3)), 1'b0);
               4'd7: c = mk(KIND_WRITE, j.data, 1'b0);
               4'd8: c = mk(KIND_CMD, CMD_PROG_GO, 1'b0);
               4'd9: c = mk(KIND_WAIT, 8'h00, 1'b0);
               4'd10: c = mk(KIND_CMD, CMD_STATUS, 1'b0);
               4'd11: c = mk(KIND_READ, 8'h00, 1'b0);
               default: c = mk(KIND_DESEL, 8'h00, 1'b1);
            endcase
         end
         REC_ERASE: begin
            unique case (s)
               4'd0: c = mk(KIND_SEL, 8'h00, 1'b0);
               4'd1: c = mk(KIND_CLRRB, 8'h00, 1'b0);
               4'd2: c = mk(KIND_CMD, CMD_ERASE, 1'b0);
               4'd3, 4'd4, 4'd5:
                  c = mk(KIND_ADDR, addr_byte(j, 2'(s - 4'd2)), 1'b0);
               4'd6: c = mk(KIND_CMD, CMD_ERASE_GO, 1'b0);
               4'd7: c = mk(KIND_WAIT, 8'h00, 1'b0);
               4'd8: c = mk(KIND_CMD, CMD_STATUS, 1'b0);
               4'd9: c = mk(KIND_READ, 8'h00, 1'b0);
               default: c = mk(KIND_DESEL, 8'h00, 1'b1);
            endcase
         end
         default: c = mk(KIND_ALIGN, 8'h00, 1'b1);
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> src/ncs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NAND command sequencer front end
// Accepts requests, checks alignment, picks the recipe and command byte,
// and hands the classified job to the queue.
// ----------------------------------------------------------------------------
module ncs_front
   import ncs_pkg::*;
#(
   parameter int ERASE_BITS = ERASE_ALIGN_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_operation,
   input  wire logic [31:0] req_flash_address,
   input  wire logic        req_spare_area,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        q_full,
   output logic             q_push,
   output job_type          q_job
);

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    known;
   logic    take;
   logic    page_bad, erase_bad;

   // Hold while the queue is full
   assign busy   = valid_ff & q_full;
   assign q_push = valid_ff & ~q_full;
   assign q_job  = job_ff;
   assign take   = start & ~busy;

   assign page_bad  = |req_flash_address[PAGE_BITS-1:0];
   assign erase_bad = |req_flash_address[ERASE_BITS-1:0];

   // Classify the request
   always_comb begin
      job_in.cmd    = CMD_READ0;
      job_in.data   = req_data_byte;
      job_in.addr0  = req_flash_address[7:0];
      job_in.addr1  = req_flash_address[16:9];
      job_in.addr2  = req_flash_address[24:17];
      job_in.addr3  = {1'b0, req_flash_address[31:25]};
      job_in.recipe = REC_ALIGN;
      known         = 1'b1;
      unique case (req_operation)
         OP_READ_SETUP: begin
            job_in.recipe = page_bad ? REC_ALIGN : REC_READ_SETUP;
            job_in.cmd    = CMD_READ0;
         end
         OP_PROG_SETUP: begin
            job_in.recipe = page_bad ? REC_ALIGN : REC_PROG_SETUP;
            job_in.cmd    = CMD_PROG;
         end
         OP_PROG_COMMIT: job_in.recipe = REC_COMMIT;
         OP_BYTE_READ: begin
            job_in.recipe = REC_BYTE_READ;
            priority if (req_spare_area)
               job_in.cmd = CMD_READ_OOB;
            else if (req_flash_address[HALF_PAGE_BIT])
               job_in.cmd = CMD_READ1;
            else
               job_in.cmd = CMD_READ0;
         end
         OP_BYTE_PROG: job_in.recipe = REC_BYTE_PROG;
         OP_ERASE:     job_in.recipe = erase_bad ? REC_ALIGN : REC_ERASE;
         OP_VERDICT: begin
            job_in.recipe = REC_VERDICT;
            job_in.data   = {7'd0, req_data_byte[0]};
         end
         OP_SELECT:     job_in.recipe = REC_SELECT;
         OP_DESELECT:   job_in.recipe = REC_DESELECT;
         OP_WRITE_DATA: job_in.recipe = REC_WRITE;
         OP_READ_DATA:  job_in.recipe = REC_READ;
         default:       known = 1'b0;
      endcase
   end

   // Drop unknown codes; keep the staged job until the queue takes it
   always_comb begin
      if (take) begin
         valid_in = known;
      end else begin
         valid_in = valid_ff & q_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

endmodule
`default_nettype wire

>>> src/ncs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NAND command sequencer job queue
// Short FIFO of classified jobs between the front end and the sequencer.
// ----------------------------------------------------------------------------
module ncs_queue
   import ncs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue popped while empty");

endmodule
`default_nettype wire

>>> src/ncs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NAND command sequencer back end
// Walks the recipe of the job at the queue head, one bus cycle word per
// clock, and registers each word onto the result ports.
// ----------------------------------------------------------------------------
module ncs_back
   import ncs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire job_type    head_job,
   output logic            pop,
   output logic            rsp_strobe,
   output logic [3:0]      rsp_cycle_kind,
   output logic [7:0]      rsp_cycle_value,
   output logic            rsp_last_cycle
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              strobe_ff, strobe_in;
   cycle_type         word_ff;
   cycle_type         word;

   assign word = seq_cycle(head_job, step_ff);
   assign pop  = head_valid & word.last;

   // Advance through the recipe; restart on its last word
   always_comb begin
      strobe_in = head_valid;
      step_in   = step_ff;
      if (head_valid) begin
         step_in = word.last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_valid) begin
         word_ff <= word;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_cycle_kind  = word_ff.kind;
   assign rsp_cycle_value = word_ff.value;
   assign rsp_last_cycle  = word_ff.last;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(MAX_STEPS - 1))
      else $error("sequencer step past longest recipe");

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      step_ff != '0 |-> head_valid)
      else $error("job left the queue head mid recipe");

endmodule
`default_nettype wire

>>> src/nand_command_sequencer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NAND command sequencer unit
// Turns host requests into the ordered bus cycles of a small-page NAND.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. It yields
// one to thirteen result words on rsp_*, one per clock with rsp_strobe high,
// the final one with rsp_last_cycle set; byte program is the longest at
// thirteen words. Its job is registered in the front stage, then in the job
// queue, and its words in the output register; words of successive requests
// follow without gaps while the next job waits in the queue. The receiver must
// take every word in the cycle it is shown. The back sequencer emits one word
// per clock while a job is queued; the front stage and a small job queue
// (QUEUE_DEPTH entries) keep accepting requests meanwhile, and busy rises only when both are full.
// Unknown operation codes are accepted and produce no words.
// ----------------------------------------------------------------------------
module nand_command_sequencer_unit
   import ncs_pkg::*;
#(
   parameter int ERASE_BITS  = ERASE_ALIGN_BITS,
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_operation,
   input  wire logic [31:0] req_flash_address,
   input  wire logic        req_spare_area,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_strobe,
   output logic [3:0]       rsp_cycle_kind,
   output logic [7:0]       rsp_cycle_value,
   output logic             rsp_last_cycle
);

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    head_valid;
   job_type head_job;

   ncs_front #(
      .ERASE_BITS (ERASE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_flash_address (req_flash_address),
      .req_spare_area    (req_spare_area),
      .req_data_byte     (req_data_byte),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (q_job)
   );

   ncs_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ncs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_cycle_kind  (rsp_cycle_kind),
      .rsp_cycle_value (rsp_cycle_value),
      .rsp_last_cycle  (rsp_last_cycle)
   );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// NAND command sequencer testbench
// Drives host requests into the sequencer and checks every bus cycle word it
// emits against an independent prediction of the cycle list for each request,
// in order and field by field. A directed pass covers address extremes,
// alignment errors, the three byte-read commands and every operation; a
// random pass runs program, read, erase and byte flows mixed with noise.
// ----------------------------------------------------------------------------
module tb_top;
   import ncs_pkg::*;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } bus_word_type;

   // Predict the bus cycles of each request and match emitted words in order
   class bus_cycle_checker;
      bus_word_type expected_cycles[$];
      int           errors = 0;

      function void push_cycle(kind_type kind, logic [7:0] value);
         bus_word_type w;
         w.kind  = kind;
         w.value = value;
         w.last  = 1'b0;
         expected_cycles.push_back(w);
      endfunction

      function void push_address(logic [31:0] addr, bit with_column);
         if (with_column) push_cycle(KIND_ADDR, addr[7:0]);
         push_cycle(KIND_ADDR, addr[16:9]);
         push_cycle(KIND_ADDR, addr[24:17]);
         push_cycle(KIND_ADDR, {1'b0, addr[31:25]});
      endfunction

      function void predict_cycles(logic [3:0] op, logic [31:0] addr, logic spare,
                                   logic [7:0] data);
         int         first_idx;
         logic [7:0] read_cmd;
         logic [31:0] erase_mask;
         first_idx  = expected_cycles.size();
         erase_mask = (32'd1 << ERASE_ALIGN_BITS) - 32'd1;
         case (op)
            OP_READ_SETUP, OP_PROG_SETUP: begin
               if (addr[PAGE_BITS-1:0] != '0) begin
                  push_cycle(KIND_ALIGN, 8'h00);
               end else begin
                  push_cycle(KIND_CLRRB, 8'h00);
                  push_cycle(KIND_CMD, (op == OP_READ_SETUP) ? CMD_READ0 : CMD_PROG);
                  push_address(addr, 1'b1);
                  if (op == OP_READ_SETUP) push_cycle(KIND_WAIT, 8'h00);
               end
            end
            OP_PROG_COMMIT: begin
               push_cycle(KIND_CMD, CMD_PROG_GO);
               push_cycle(KIND_WAIT, 8'h00);
               push_cycle(KIND_CMD, CMD_STATUS);
               push_cycle(KIND_READ, 8'h00);
            end
            OP_BYTE_READ: begin
               if (spare) read_cmd = CMD_READ_OOB;
               else if (addr[HALF_PAGE_BIT]) read_cmd = CMD_READ1;
               else read_cmd = CMD_READ0;
               push_cycle(KIND_SEL, 8'h00);
               push_cycle(KIND_CLRRB, 8'h00);
               push_cycle(KIND_CMD, read_cmd);
               push_address(addr, 1'b1);
               push_cycle(KIND_WAIT, 8'h00);
               push_cycle(KIND_READ, 8'h00);
               push_cycle(KIND_DESEL, 8'h00);
            end
            OP_BYTE_PROG: begin
               push_cycle(KIND_SEL, 8'h00);
               push_cycle(KIND_CLRRB, 8'h00);
               push_cycle(KIND_CMD, CMD_PROG);
               push_address(addr, 1'b1);
               push_cycle(KIND_WRITE, data);
               push_cycle(KIND_CMD, CMD_PROG_GO);
               push_cycle(KIND_WAIT, 8'h00);
               push_cycle(KIND_CMD, CMD_STATUS);
               push_cycle(KIND_READ, 8'h00);
               push_cycle(KIND_DESEL, 8'h00);
            end
            OP_ERASE: begin
               if ((addr & erase_mask) != 32'd0) begin
                  push_cycle(KIND_ALIGN, 8'h00);
               end else begin
                  push_cycle(KIND_SEL, 8'h00);
                  push_cycle(KIND_CLRRB, 8'h00);
                  push_cycle(KIND_CMD, CMD_ERASE);
                  push_address(addr, 1'b0);
                  push_cycle(KIND_CMD, CMD_ERASE_GO);
                  push_cycle(KIND_WAIT, 8'h00);
                  push_cycle(KIND_CMD, CMD_STATUS);
                  push_cycle(KIND_READ, 8'h00);
                  push_cycle(KIND_DESEL, 8'h00);
               end
            end
            OP_VERDICT:    push_cycle(KIND_VERDICT, {7'd0, data[0]});
            OP_SELECT:     push_cycle(KIND_SEL, 8'h00);
            OP_DESELECT:   push_cycle(KIND_DESEL, 8'h00);
            OP_WRITE_DATA: push_cycle(KIND_WRITE, data);
            OP_READ_DATA:  push_cycle(KIND_READ, 8'h00);
            default: ;
         endcase
         // mark the final cycle of this request
         if (expected_cycles.size() > first_idx)
            expected_cycles[expected_cycles.size()-1].last = 1'b1;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_word(logic [3:0] kind, logic [7:0] value, logic last);
         bus_word_type w;
         if (expected_cycles.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind=%0d value=%02h last=%0b",
                                      kind, value, last));
         end else begin
            w = expected_cycles.pop_front();
            if (kind !== w.kind || value !== w.value || last !== w.last)
               report_mismatch($sformatf("got kind=%0d value=%02h last=%0b, want %0d %02h %0b",
                                         kind, value, last, w.kind, w.value, w.last));
         end
      endtask

      function int pending();
         return expected_cycles.size();
      endfunction
   endclass

   localparam int DIRECTED_ITEMS = 24;
   localparam int RANDOM_ITEMS   = 96;
   localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
   localparam int QUIET_TAIL     = 20;
   localparam int DRAIN_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_operation = '0;
   logic [31:0] req_flash_address = '0;
   logic        req_spare_area = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_strobe;
   logic [3:0]  rsp_cycle_kind;
   logic [7:0]  rsp_cycle_value;
   logic        rsp_last_cycle;

   bus_cycle_checker bus_check = new();
   int               items_sent = 0;
   bit               idle_on = 1'b0;

   nand_command_sequencer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_flash_address (req_flash_address),
      .req_spare_area    (req_spare_area),
      .req_data_byte     (req_data_byte),
      .rsp_strobe        (rsp_strobe),
      .rsp_cycle_kind    (rsp_cycle_kind),
      .rsp_cycle_value   (rsp_cycle_value),
      .rsp_last_cycle    (rsp_last_cycle)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Check every emitted word at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         bus_check.check_word(rsp_cycle_kind, rsp_cycle_value, rsp_last_cycle);
   end

   // Present one request word and hold it until the sequencer takes it
   task send_request(logic [3:0] op, logic [31:0] addr, logic spare, logic [7:0] data);
      req_operation     <= op;
      req_flash_address <= addr;
      req_spare_area    <= spare;
      req_data_byte     <= data;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      bus_check.predict_cycles(op, addr, spare, data);
      items_sent++;
   endtask

   task idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // Insert a random gap unless in a quiet stretch or the tail of the run
   task maybe_idle();
      if (idle_on && items_sent < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
         idle_burst();
   endtask

   task send(logic [3:0] op, logic [31:0] addr, logic spare, logic [7:0] data);
      send_request(op, addr, spare, data);
      maybe_idle();
   endtask

   // Hold off new requests until every predicted word has come out
   task drain_pending();
      int waited;
      waited = 0;
      start <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (bus_check.pending() != 0 && waited < DRAIN_LIMIT);
   endtask

   function logic [31:0] page_addr(bit misalign);
      logic [31:0] a;
      a = $urandom;
      return misalign ? (a | 32'h1) : (a & ~32'h1FF);
   endfunction

   function logic [31:0] block_addr(bit misalign);
      logic [31:0] a;
      a = $urandom & ~((32'd1 << ERASE_ALIGN_BITS) - 32'd1);
      return misalign ? (a | (32'd1 << $urandom_range(0, ERASE_ALIGN_BITS-1))) : a;
   endfunction

   task program_flow();
      send(OP_SELECT, $urandom, 1'($urandom), 8'($urandom));
      send(OP_PROG_SETUP, page_addr($urandom_range(0, 7) == 0), 1'($urandom),
           8'($urandom));
      repeat ($urandom_range(1, 4))
         send(OP_WRITE_DATA, $urandom, 1'($urandom), 8'($urandom));
      send(OP_PROG_COMMIT, $urandom, 1'($urandom), 8'($urandom));
      send(OP_VERDICT, $urandom, 1'($urandom), 8'($urandom));
      send(OP_DESELECT, $urandom, 1'($urandom), 8'($urandom));
   endtask

   task read_flow();
      send(OP_SELECT, $urandom, 1'($urandom), 8'($urandom));
      send(OP_READ_SETUP, page_addr($urandom_range(0, 7) == 0), 1'($urandom),
           8'($urandom));
      repeat ($urandom_range(1, 4))
         send(OP_READ_DATA, $urandom, 1'($urandom), 8'($urandom));
      send(OP_DESELECT, $urandom, 1'($urandom), 8'($urandom));
   endtask

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: alignment, address extremes, command choices, every operation
      idle_on = 1'b0;
      send(OP_READ_SETUP, 32'h0000_0000, 1'b0, 8'h00);
      send(OP_READ_SETUP, 32'hFFFF_FE00, 1'b1, 8'hFF);
      send(OP_READ_SETUP, 32'h0000_0100, 1'b0, 8'h00);
      send(OP_PROG_SETUP, 32'hA5A5_A400, 1'b0, 8'h5A);
      send(OP_PROG_SETUP, 32'h0000_01FF, 1'b1, 8'hA5);
      send(OP_PROG_COMMIT, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send(OP_BYTE_READ, 32'hFFFF_FFFF, 1'b1, 8'h00);
      send(OP_BYTE_READ, 32'h0000_0100, 1'b0, 8'hFF);
      send(OP_BYTE_READ, 32'h1234_5600, 1'b0, 8'h00);
      send(OP_BYTE_PROG, 32'hFFFF_FFFF, 1'b0, 8'hFF);
      send(OP_BYTE_PROG, 32'h0000_0000, 1'b1, 8'h00);
      send(OP_ERASE, 32'hFFFF_C000, 1'b0, 8'h00);
      send(OP_ERASE, 32'h0000_2000, 1'b0, 8'h00);
      send(OP_ERASE, 32'h0000_0001, 1'b1, 8'hFF);
      send(OP_VERDICT, 32'h0, 1'b0, 8'hFE);
      send(OP_VERDICT, 32'h0, 1'b0, 8'hFF);
      send(OP_SELECT, 32'h0, 1'b0, 8'h00);
      send(OP_DESELECT, 32'h0, 1'b0, 8'h00);
      send(OP_WRITE_DATA, 32'h0, 1'b0, 8'hAA);
      send(OP_WRITE_DATA, 32'h0, 1'b0, 8'h55);
      send(OP_READ_DATA, 32'h0, 1'b0, 8'h00);
      send(4'd11, 32'hFFFF_FFFF, 1'b1, 8'hFF);
      send(4'd15, 32'h0, 1'b0, 8'h00);
      send(OP_ERASE, 32'h0000_0000, 1'b1, 8'h81);

      // random: mostly well-formed flows, the rest single requests and noise
      while (items_sent < TOTAL_ITEMS) begin
         idle_on = ($urandom_range(0, 2) != 0);
         if (!drained && items_sent >= TOTAL_ITEMS / 2) begin
            drain_pending();
            drained = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: program_flow();
            3, 4:    read_flow();
            5: begin
               send(OP_ERASE, block_addr($urandom_range(0, 5) == 0), 1'($urandom),
                    8'($urandom));
               send(OP_VERDICT, $urandom, 1'($urandom), 8'($urandom));
            end
            6: begin
               send(OP_BYTE_READ, $urandom, 1'($urandom), 8'($urandom));
               send(OP_BYTE_PROG, $urandom, 1'($urandom), 8'($urandom));
               send(OP_VERDICT, $urandom, 1'($urandom), 8'($urandom));
            end
            default: send(4'($urandom_range(0, 15)), $urandom, 1'($urandom),
                          8'($urandom));
         endcase
      end

      // let the last words out, then allow for stray ones
      drain_pending();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bus_check.pending() != 0)
         bus_check.report_mismatch($sformatf("%0d expected words never arrived",
                                             bus_check.pending()));
      if (bus_check.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
